// File: rtl/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg: shared types and helpers of the segmented sweep sequencer
// Holds the register map, the item and state records and the small
// segment arithmetic that both the update logic and the top level use.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int MAX_SEGMENTS = 4;
    localparam int ANGLE_W      = 18;
    localparam int SEG_W        = 2;
    localparam int CNT_W        = 3;
    localparam int SEGANG_W     = 16;
    localparam int DWELL_W      = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;
    localparam logic [DWELL_W-1:0] DWELL_MAX = '1;

    // action codes carried in the input tuser
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_SEGMENT_COUNT  = 3'd0;
    localparam logic [2:0] CFG_SEGMENT_ANGLES = 3'd1;
    localparam logic [2:0] CFG_ROTATION_RATE  = 3'd2;
    localparam logic [2:0] CFG_WARNING_ANGLE  = 3'd3;
    localparam logic [2:0] CFG_PAUSE_SEGMENTS = 3'd4;
    localparam logic [2:0] CFG_PAUSE_SCANS    = 3'd5;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_SCANNING = 2'd1,
        MODE_PAUSED   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [CNT_W-1:0]    segment_count;
        logic [63:0]         segment_angles;
        logic [15:0]         rotation_rate;
        logic [15:0]         warning_angle;
        logic [DWELL_W-1:0]  pause_segments;
        logic [DWELL_W-1:0]  pause_scans;
    } t_cfg;

    typedef struct packed {
        t_mode               mode;
        logic [ANGLE_W-1:0]  angle_now;
        logic [ANGLE_W-1:0]  segment_start_angle;
        logic [SEG_W-1:0]    segment_now;
        logic [DWELL_W-1:0]  dwell_counter;
        logic [DWELL_W-1:0]  dwell_length;
        logic                warned;
    } t_state;

    typedef struct packed {
        logic [1:0]          action;
        logic [15:0]         delta_time;
        logic [SEG_W-1:0]    start_segment;
    } t_item;

    typedef struct packed {
        t_mode               run_state;
        logic [ANGLE_W-1:0]  sweep_angle;
        logic [SEG_W-1:0]    segment_index;
        logic                ending_event;
        logic                state_change_event;
        logic                bad_segment;
    } t_result;

    // segment count clamped to 1..MAX_SEGMENTS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] c;
        c = cnt;
        if (c == '0) begin
            c = CNT_W'(1);
        end else if (c > CNT_W'(MAX_SEGMENTS)) begin
            c = CNT_W'(MAX_SEGMENTS);
        end
        return c;
    endfunction

    // angle of one segment
    function automatic logic [SEGANG_W-1:0] seg_angle(input logic [63:0] angles,
                                                      input logic [SEG_W-1:0] idx);
        return angles[{idx, 4'b0000} +: SEGANG_W];
    endfunction

    // sum of the segment angles below idx
    function automatic logic [ANGLE_W-1:0] prefix_angle(input logic [63:0] angles,
                                                        input logic [SEG_W-1:0] idx);
        logic [ANGLE_W-1:0] s1;
        logic [ANGLE_W-1:0] s2;
        logic [ANGLE_W-1:0] s3;
        logic [ANGLE_W-1:0] sum;
        s1 = ANGLE_W'(angles[15:0]);
        s2 = s1 + ANGLE_W'(angles[31:16]);
        s3 = s2 + ANGLE_W'(angles[47:32]);
        unique case (idx)
            2'd0:    sum = '0;
            2'd1:    sum = s1;
            2'd2:    sum = s2;
            default: sum = s3;
        endcase
        return sum;
    endfunction

    // (seg + 1) mod cnt, cnt already clamped to 1..4
    function automatic logic [SEG_W-1:0] next_segment(input logic [SEG_W-1:0] seg,
                                                      input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] v;
        logic [SEG_W-1:0] r;
        v = {1'b0, seg} + CNT_W'(1);
        unique case (cnt)
            3'd1:    r = '0;
            3'd2:    r = {1'b0, v[0]};
            3'd3:    r = (v >= 3'd3) ? SEG_W'(v - 3'd3) : v[SEG_W-1:0];
            default: r = v[SEG_W-1:0];
        endcase
        return r;
    endfunction

endpackage

// File: rtl/sss_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_step: per-item state update
// Takes the current sequencer state and one item and gives the next state
// and the result fields in a single combinational pass.
// ----------------------------------------------------------------------------
module sss_step (
    input  sss_pkg::t_cfg    i_cfg,
    input  sss_pkg::t_state  i_state,
    input  sss_pkg::t_item   i_item,
    output sss_pkg::t_state  o_state,
    output sss_pkg::t_result o_result
);

    logic [sss_pkg::CNT_W-1:0]    w_cnt;
    logic [sss_pkg::SEGANG_W-1:0] w_seg_len;
    logic [sss_pkg::ANGLE_W-1:0]  w_so_far;
    logic [sss_pkg::ANGLE_W-1:0]  w_remain;
    logic                         w_done;
    logic                         w_warn_hit;
    logic [31:0]                  w_product;
    logic [sss_pkg::ANGLE_W:0]    w_angle_sum;
    logic [sss_pkg::ANGLE_W-1:0]  w_angle_sat;
    logic [sss_pkg::DWELL_W:0]    w_dwell_sum;
    logic [sss_pkg::DWELL_W-1:0]  w_dwell_sat;
    logic [sss_pkg::DWELL_W-1:0]  w_dwell_pick;
    logic [sss_pkg::SEG_W-1:0]    w_seg_next;
    logic                         w_ending;
    logic                         w_changed;
    logic                         w_bad;

    // progress through the current segment and the warning test
    always_comb begin
        w_cnt      = sss_pkg::eff_count(i_cfg.segment_count);
        w_seg_len  = sss_pkg::seg_angle(i_cfg.segment_angles, i_state.segment_now);
        w_so_far   = (i_state.angle_now >= i_state.segment_start_angle)
                     ? (i_state.angle_now - i_state.segment_start_angle) : '0;
        w_done     = w_so_far >= sss_pkg::ANGLE_W'(w_seg_len);
        w_remain   = sss_pkg::ANGLE_W'(w_seg_len) - w_so_far;
        w_warn_hit = w_done || (w_remain <= sss_pkg::ANGLE_W'(i_cfg.warning_angle));
    end

    // angle step and saturating angle and dwell sums
    always_comb begin
        w_product   = 32'(i_item.delta_time) * 32'(i_cfg.rotation_rate);
        w_angle_sum = {1'b0, i_state.angle_now} + (sss_pkg::ANGLE_W+1)'(w_product[31:16]);
        w_angle_sat = w_angle_sum[sss_pkg::ANGLE_W] ? sss_pkg::ANGLE_MAX
                                                    : w_angle_sum[sss_pkg::ANGLE_W-1:0];
        w_dwell_sum = {1'b0, i_state.dwell_counter}
                      + (sss_pkg::DWELL_W+1)'(i_item.delta_time);
        w_dwell_sat = w_dwell_sum[sss_pkg::DWELL_W] ? sss_pkg::DWELL_MAX
                                                    : w_dwell_sum[sss_pkg::DWELL_W-1:0];
        w_dwell_pick = (({1'b0, i_state.segment_now} + sss_pkg::CNT_W'(1)) < w_cnt)
                       ? i_cfg.pause_segments : i_cfg.pause_scans;
        w_seg_next  = sss_pkg::next_segment(i_state.segment_now, w_cnt);
    end

    // next state by action and mode
    always_comb begin
        o_state   = i_state;
        w_ending  = 1'b0;
        w_changed = 1'b0;
        w_bad     = 1'b0;
        unique case (i_item.action)
            sss_pkg::ACT_START: begin
                if ({1'b0, i_item.start_segment} >= w_cnt) begin
                    w_bad = 1'b1;
                end else begin
                    o_state.segment_now         = i_item.start_segment;
                    o_state.segment_start_angle = sss_pkg::prefix_angle(
                        i_cfg.segment_angles, i_item.start_segment);
                    o_state.angle_now           = o_state.segment_start_angle;
                    o_state.mode                = sss_pkg::MODE_SCANNING;
                    o_state.warned              = 1'b0;
                    w_changed                   = 1'b1;
                end
            end
            sss_pkg::ACT_STOP: begin
                o_state.mode   = sss_pkg::MODE_STOPPED;
                o_state.warned = 1'b0;
                w_changed      = 1'b1;
            end
            sss_pkg::ACT_TICK: begin
                case (i_state.mode)
                    sss_pkg::MODE_PAUSED: begin
                        o_state.dwell_counter = w_dwell_sat;
                        if (w_dwell_sat >= i_state.dwell_length) begin
                            o_state.mode   = sss_pkg::MODE_SCANNING;
                            o_state.warned = 1'b0;
                            w_changed      = 1'b1;
                        end
                    end
                    sss_pkg::MODE_SCANNING: begin
                        if (!i_state.warned && w_warn_hit) begin
                            o_state.warned = 1'b1;
                            w_ending       = 1'b1;
                        end
                        o_state.angle_now = w_angle_sat;
                        // segment finished: move on to the next one and pause there
                        if (w_done) begin
                            o_state.mode                = sss_pkg::MODE_PAUSED;
                            o_state.dwell_counter       = '0;
                            o_state.dwell_length        = w_dwell_pick;
                            o_state.warned              = 1'b0;
                            o_state.segment_now         = w_seg_next;
                            o_state.segment_start_angle = sss_pkg::prefix_angle(
                                i_cfg.segment_angles, w_seg_next);
                            o_state.angle_now           = o_state.segment_start_angle;
                            w_changed                   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // result fields report the state after this item
    always_comb begin
        o_result.run_state          = o_state.mode;
        o_result.sweep_angle        = o_state.angle_now;
        o_result.segment_index      = o_state.segment_now;
        o_result.ending_event       = w_ending;
        o_result.state_change_event = w_changed;
        o_result.bad_segment        = w_bad;
    end

endmodule

// File: rtl/segmented_sweep_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_sweep_sequencer: sweep angle sequencer over a ring of segments
// Ticks advance the angle, starts and stops set the run state; every item
// gives exactly one result item with the state after it.
// ----------------------------------------------------------------------------
// One item per clock cycle is accepted while the output side is ready, and one
// result per item is returned from the result register. Items pass an
// input register, then one pass of update logic (a 16x16 multiply for the
// angle step, a saturating add and the segment compares) that writes both the
// state and the result register, so this single pass of state update sets the
// rate. A result waiting on the output stops the next item from entering the
// input register only while that register is full. Configuration writes take
// effect on the next cycle and are meant to be done while no item is in flight.
// ----------------------------------------------------------------------------
module segmented_sweep_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // delta_time[15:0], start_segment[17:16]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // run_state[1:0], sweep_angle[19:2],
                                        // segment_index[21:20], ending_event[22],
                                        // state_change_event[23], bad_segment[24]
);

    sss_pkg::t_cfg    r_cfg;
    sss_pkg::t_state  r_state;
    sss_pkg::t_state  n_state;
    sss_pkg::t_item   r_in;
    sss_pkg::t_result w_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic [31:0]      r_out_tdata;
    logic [31:0]      n_out_tdata;
    logic             w_out_free;
    logic             w_fire;

    // handshake between the two register stages
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.segment_count  <= sss_pkg::CNT_W'(1);
            r_cfg.segment_angles <= 64'd46080;
            r_cfg.rotation_rate  <= 16'd11520;
            r_cfg.warning_angle  <= '0;
            r_cfg.pause_segments <= '0;
            r_cfg.pause_scans    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sss_pkg::CFG_SEGMENT_COUNT:  r_cfg.segment_count  <= i_cfg_data[2:0];
                sss_pkg::CFG_SEGMENT_ANGLES: r_cfg.segment_angles <= i_cfg_data;
                sss_pkg::CFG_ROTATION_RATE:  r_cfg.rotation_rate  <= i_cfg_data[15:0];
                sss_pkg::CFG_WARNING_ANGLE:  r_cfg.warning_angle  <= i_cfg_data[15:0];
                sss_pkg::CFG_PAUSE_SEGMENTS: r_cfg.pause_segments <= i_cfg_data[31:0];
                sss_pkg::CFG_PAUSE_SCANS:    r_cfg.pause_scans    <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // valid bits and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: sss_pkg::MODE_STOPPED, default: '0};
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    // input item register
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in.action        <= s_axis_tuser;
            r_in.delta_time    <= s_axis_tdata[15:0];
            r_in.start_segment <= s_axis_tdata[17:16];
        end
    end

    // state update for the item in the input register
    sss_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // result packing
    always_comb begin
        n_out_tdata = {7'b0, w_result.bad_segment, w_result.state_change_event,
                       w_result.ending_event, w_result.segment_index,
                       w_result.sweep_angle, w_result.run_state};
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_tdata <= n_out_tdata;
        end
    end

endmodule

// File: rtl/sss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_checker: port-level checks of the sweep sequencer
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module sss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] i_m_axis_tdata
);

    logic w_ending;
    logic w_changed;
    logic w_bad;

    assign w_ending  = i_m_axis_tdata[22];
    assign w_changed = i_m_axis_tdata[23];
    assign w_bad     = i_m_axis_tdata[24];

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid)
        else $error("result dropped while stalled");

    // an empty output side never blocks the input
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_axis_tvalid |-> i_s_axis_tready)
        else $error("input blocked with empty output");

    // a rejected start changes nothing and raises no other event
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && w_bad |-> !w_changed && !w_ending)
        else $error("rejected start raised another event");

    // the ending warning only comes from a scanning tick
    a_ending_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && w_ending |->
            i_m_axis_tdata[1:0] != sss_pkg::MODE_STOPPED)
        else $error("ending warning while stopped");

endmodule

bind segmented_sweep_sequencer sss_checker u_sss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (s_axis_tready),
    .i_m_axis_tvalid (m_axis_tvalid),
    .i_m_axis_tready (m_axis_tready),
    .i_m_axis_tdata  (m_axis_tdata)
);
